>>> src/keyframe_joint_interpolator_unit_macros.svh
// ----------------------------------------------------------------------------
// Keyframe joint interpolator assertion macros
// Shared assertion forms for the checker of the interpolator.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_JOINT_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_JOINT_INTERPOLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KJIP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KJIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/kjip_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe joint interpolator package
// Shared constants, payload structs, the queued command and the engine states.
// ----------------------------------------------------------------------------
package kjip_pkg;

   localparam int KJIP_JOINTS     = 25;
   localparam int KJIP_MAX_FRAMES = 64;
   localparam int KJIP_NUM_W      = 34;
   localparam int KJIP_DIV_STEPS  = 34;

   typedef enum logic [1:0] {
      OP_FRAME_TIME  = 2'd0,
      OP_FRAME_ANGLE = 2'd1,
      OP_START_ANGLE = 2'd2,
      OP_TICK        = 2'd3
   } kjip_op_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [5:0]         frame_index;
      logic [4:0]         joint_index;
      logic [15:0]        time_ms;
      logic signed [15:0] position;
   } kjip_req_type;

   typedef struct packed {
      logic [4:0]         joint_out;
      logic signed [15:0] angle_out;
      logic               last_joint;
      logic               motion_done;
   } kjip_rsp_type;

   // A classified item as it travels from the front to the engine.
   typedef struct packed {
      kjip_op_type        op;
      logic               frame_ok;
      logic               joint_ok;
      logic [5:0]         frame_index;
      logic [4:0]         joint_index;
      logic [15:0]        time_ms;
      logic signed [15:0] position;
   } kjip_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SETUP,
      ST_RD_A,
      ST_RD_B,
      ST_MUL_A,
      ST_MUL_B,
      ST_NORM,
      ST_DIV,
      ST_EMIT,
      ST_DONE
   } kjip_state_type;

endpackage

>>> src/kjip_front.sv
// ----------------------------------------------------------------------------
// Keyframe joint interpolator front
// Accepts items, checks their addresses and queues them for the engine.
// ----------------------------------------------------------------------------
module kjip_front #(
   parameter int JOINTS     = kjip_pkg::KJIP_JOINTS,
   parameter int MAX_FRAMES = kjip_pkg::KJIP_MAX_FRAMES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kjip_pkg::kjip_req_type req_payload,
   output logic                   cmd_valid,
   input  logic                   cmd_pop,
   output kjip_pkg::kjip_cmd_type cmd_data
);
   import kjip_pkg::*;

   kjip_cmd_type cmd_in;
   kjip_cmd_type queue_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   // Classify the incoming item and flag addresses outside the tables.
   always_comb begin
      cmd_in.op          = kjip_op_type'(req_payload.operation);
      cmd_in.frame_ok    = {3'b000, req_payload.frame_index} < 9'(MAX_FRAMES);
      cmd_in.joint_ok    = {1'b0, req_payload.joint_index} < 6'(JOINTS);
      cmd_in.frame_index = req_payload.frame_index;
      cmd_in.joint_index = req_payload.joint_index;
      cmd_in.time_ms     = req_payload.time_ms;
      cmd_in.position    = req_payload.position;
   end

   // Two-entry queue between the front and the engine.
   assign req_stall = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

>>> src/kjip_engine.sv
// ----------------------------------------------------------------------------
// Keyframe joint interpolator engine
// Holds the tables, executes loads and runs the search and interpolation.
// ----------------------------------------------------------------------------
module kjip_engine #(
   parameter int JOINTS     = kjip_pkg::KJIP_JOINTS,
   parameter int MAX_FRAMES = kjip_pkg::KJIP_MAX_FRAMES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [6:0]             csr_write_data,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  kjip_pkg::kjip_cmd_type cmd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kjip_pkg::kjip_rsp_type rsp_payload
);
   import kjip_pkg::*;

   localparam int FW = $clog2(MAX_FRAMES);
   localparam int AW = $clog2(MAX_FRAMES * JOINTS);
   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   kjip_state_type state_ff, state_in;

   logic [6:0]            frame_count_ff;
   logic [15:0]           t_ff, t_in;
   logic [8:0]            idx_ff, idx_in;
   logic [8:0]            n_ff, n_in, n_now;
   logic                  have_prev_ff, have_prev_in;
   logic                  have_next_ff, have_next_in;
   logic [FW-1:0]         prev_ff, prev_in;
   logic [FW-1:0]         next_ff, next_in;
   logic [15:0]           tp_ff, tp_in;
   logic [15:0]           tn_ff, tn_in;
   logic                  last_ge_ff, last_ge_in;
   logic [4:0]            joint_ff, joint_in;
   logic [AW-1:0]         addr_a_ff, addr_a_in;
   logic [AW-1:0]         addr_b_ff, addr_b_in;
   logic signed [15:0]    a_ff, a_in;
   logic signed [15:0]    b_ff, b_in;
   logic signed [32:0]    prod_ff, prod_in;
   logic signed [KJIP_NUM_W-1:0] num_ff, num_in;
   logic                  neg_ff, neg_in;
   logic [16:0]           den_ff, den_in;
   logic [16:0]           rem_ff, rem_in;
   logic [KJIP_NUM_W-1:0] quot_ff, quot_in;
   logic [5:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kjip_rsp_type          rsp_ff, rsp_in;

   // Table storage.
   logic [15:0]        ft_mem [MAX_FRAMES];
   logic [15:0]        ft_rd_ff;
   logic signed [15:0] ang_mem [MAX_FRAMES * JOINTS];
   logic signed [15:0] ang_rd_ff;
   logic signed [15:0] st_mem [JOINTS];
   logic [JOINTS-1:0]  st_valid_ff;
   logic signed [15:0] st_rd_ff;

   logic               ft_we, ang_we, st_we;
   logic [FW-1:0]      ft_waddr;
   logic [AW-1:0]      ang_waddr;
   logic [JW-1:0]      st_waddr;
   logic [FW-1:0]      ft_raddr;
   logic [AW-1:0]      ang_raddr;
   logic [8:0]         fi_wide;

   logic               out_free;
   logic               scan_ge;
   logic [16:0]        rem_shift;
   logic               emit_last;
   logic [15:0]        mag16;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign scan_ge     = (t_ff >= ft_rd_ff);
   assign emit_last   = ({27'd0, joint_ff} == 32'(JOINTS - 1));
   assign n_now       = ({2'b00, frame_count_ff} > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES)
                                                                : {2'b00, frame_count_ff};
   assign rem_shift   = {rem_ff[15:0], quot_ff[KJIP_NUM_W-1]};
   assign mag16       = quot_ff[15:0];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign fi_wide     = {3'b000, cmd_data.frame_index};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_data.op == OP_TICK) begin
               state_in = (n_now == 9'd0) ? ST_DONE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = (idx_ff + 9'd1 == n_ff) ? ST_SETUP : ST_SCAN_RD;
         ST_SETUP:    state_in = last_ge_ff ? ST_DONE : ST_RD_A;
         ST_RD_A:     state_in = ST_RD_B;
         ST_RD_B:     state_in = ST_MUL_A;
         ST_MUL_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_NORM;
         ST_NORM:     state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == 6'(KJIP_DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_RD_A;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control for each state.
   always_comb begin
      t_in         = t_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      have_prev_in = have_prev_ff;
      have_next_in = have_next_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      tp_in        = tp_ff;
      tn_in        = tn_ff;
      last_ge_in   = last_ge_ff;
      joint_in     = joint_ff;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      ft_we        = 1'b0;
      ang_we       = 1'b0;
      st_we        = 1'b0;
      ft_waddr     = fi_wide[FW-1:0];
      ang_waddr    = AW'(32'(cmd_data.frame_index) * JOINTS + 32'(cmd_data.joint_index));
      st_waddr     = cmd_data.joint_index[JW-1:0];
      ft_raddr     = idx_ff[FW-1:0];
      ang_raddr    = addr_a_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_FRAME_TIME:  ft_we  = cmd_data.frame_ok;
                  OP_FRAME_ANGLE: ang_we = cmd_data.frame_ok && cmd_data.joint_ok;
                  OP_START_ANGLE: st_we  = cmd_data.joint_ok;
                  OP_TICK: begin
                     t_in         = cmd_data.time_ms;
                     n_in         = n_now;
                     idx_in       = 9'd0;
                     have_prev_in = 1'b0;
                     have_next_in = 1'b0;
                     prev_in      = '0;
                     next_in      = '0;
                     tp_in        = 16'd0;
                     tn_in        = 16'd0;
                     last_ge_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_RD: ;
         ST_SCAN_CMP: begin
            // Ascending scan: the last hit is the previous frame, the first miss the next.
            last_ge_in = scan_ge;
            if (scan_ge) begin
               have_prev_in = 1'b1;
               prev_in      = idx_ff[FW-1:0];
               tp_in        = ft_rd_ff;
            end else if (!have_next_ff) begin
               have_next_in = 1'b1;
               next_in      = idx_ff[FW-1:0];
               tn_in        = ft_rd_ff;
            end
            idx_in = idx_ff + 9'd1;
         end
         ST_SETUP: begin
            addr_a_in = AW'(32'(prev_ff) * JOINTS);
            addr_b_in = AW'(32'(next_ff) * JOINTS);
            joint_in  = 5'd0;
            den_in    = {1'b0, tn_ff - tp_ff};
         end
         ST_RD_A: ang_raddr = addr_a_ff;
         ST_RD_B: begin
            a_in      = have_prev_ff ? ang_rd_ff : st_rd_ff;
            ang_raddr = addr_b_ff;
         end
         ST_MUL_A: begin
            b_in    = ang_rd_ff;
            prod_in = 33'(a_ff * $signed({1'b0, tn_ff - t_ff}));
         end
         ST_MUL_B: begin
            num_in = KJIP_NUM_W'(prod_ff) + KJIP_NUM_W'(b_ff * $signed({1'b0, t_ff - tp_ff}));
         end
         ST_NORM: begin
            neg_in  = num_ff[KJIP_NUM_W-1];
            quot_in = num_ff[KJIP_NUM_W-1] ? KJIP_NUM_W'(-num_ff) : KJIP_NUM_W'(num_ff);
            rem_in  = 17'd0;
            step_in = 6'd0;
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_shift >= den_ff) begin
               rem_in  = rem_shift - den_ff;
               quot_in = {quot_ff[KJIP_NUM_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               quot_in = {quot_ff[KJIP_NUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.joint_out   = joint_ff;
               rsp_in.angle_out   = neg_ff ? $signed(-mag16) : $signed(mag16);
               rsp_in.last_joint  = emit_last;
               rsp_in.motion_done = 1'b0;
               joint_in           = joint_ff + 5'd1;
               addr_a_in          = addr_a_ff + AW'(1);
               addr_b_in          = addr_b_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.joint_out   = 5'd0;
               rsp_in.angle_out   = 16'sd0;
               rsp_in.last_joint  = 1'b1;
               rsp_in.motion_done = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= 7'd0;
         rsp_valid_ff   <= 1'b0;
         st_valid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            frame_count_ff <= csr_write_data;
         end
         if (st_we) begin
            st_valid_ff[st_waddr] <= 1'b1;
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      have_prev_ff <= have_prev_in;
      have_next_ff <= have_next_in;
      prev_ff      <= prev_in;
      next_ff      <= next_in;
      tp_ff        <= tp_in;
      tn_ff        <= tn_in;
      last_ge_ff   <= last_ge_in;
      joint_ff     <= joint_in;
      addr_a_ff    <= addr_a_in;
      addr_b_ff    <= addr_b_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      neg_ff       <= neg_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      rsp_ff       <= rsp_in;
   end

   // Frame time memory.
   always_ff @(posedge clock) begin
      if (ft_we) begin
         ft_mem[ft_waddr] <= cmd_data.time_ms;
      end
      ft_rd_ff <= ft_mem[ft_raddr];
   end

   // Frame angle memory.
   always_ff @(posedge clock) begin
      if (ang_we) begin
         ang_mem[ang_waddr] <= cmd_data.position;
      end
      ang_rd_ff <= ang_mem[ang_raddr];
   end

   // Start angles; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= cmd_data.position;
      end
      st_rd_ff <= st_valid_ff[joint_ff[JW-1:0]] ? st_mem[joint_ff[JW-1:0]] : 16'sd0;
   end

endmodule

>>> src/keyframe_joint_interpolator_unit.sv
// ----------------------------------------------------------------------------
// Keyframe joint interpolator
// Linear interpolation of joint angles between stored keyframes.
// ----------------------------------------------------------------------------
// The req channel carries one item per transfer: a frame time load, a frame
// angle load, a start angle load or a tick. Loads produce no response and
// are written to their table as they leave the two-entry input queue. A tick
// produces either one response marked motion_done, or one response per joint
// in joint order with last_joint set on the final one.
// The csr port writes the frame count; write it only while idle.
// A tick first scans the frame time memory, a read step and a compare step per
// loaded frame, then works through each joint: two angle memory reads, two
// multiplies, a sign step, a bit-serial divider over the 34-bit numerator and
// an output step that waits while the response is stalled. The divider
// dominates the time that a tick takes.
// Synchronous reset empties the queue, clears the frame count and the start
// angles to zero, and drops any pending response. A stalled response holds
// in the output register while the queue keeps accepting up to two items.
// ----------------------------------------------------------------------------
module keyframe_joint_interpolator_unit #(
   parameter int JOINTS     = kjip_pkg::KJIP_JOINTS,
   parameter int MAX_FRAMES = kjip_pkg::KJIP_MAX_FRAMES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kjip_pkg::kjip_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kjip_pkg::kjip_rsp_type rsp_payload,
   input  logic                   csr_write_enable,
   input  logic [6:0]             csr_write_data
);
   import kjip_pkg::*;

   logic         cmd_valid;
   logic         cmd_pop;
   kjip_cmd_type cmd_data;

   // Front: accept and classify items.
   kjip_front #(
      .JOINTS     (JOINTS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data)
   );

   // Engine: tables, search and interpolation.
   kjip_engine #(
      .JOINTS     (JOINTS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_data         (cmd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

>>> src/kjip_checker.sv
// ----------------------------------------------------------------------------
// Keyframe joint interpolator checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_joint_interpolator_unit_macros.svh"

module kjip_checker #(
   parameter int JOINTS = kjip_pkg::KJIP_JOINTS
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input kjip_pkg::kjip_rsp_type rsp_payload
);
   import kjip_pkg::*;

   // A stalled response stays put.
   `KJIP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // A done response is the single marker result.
   `KJIP_ASSERT_NOW(a_done_shape, rsp_valid && rsp_payload.motion_done, rsp_payload.last_joint && rsp_payload.angle_out == 16'sd0 && rsp_payload.joint_out == 5'd0, "malformed done response")

   // Interpolated responses name a real joint.
   `KJIP_ASSERT_NOW(a_joint_range, rsp_valid, 32'(rsp_payload.joint_out) < JOINTS, "joint out of range")

   // Only the final joint of a run is marked last.
   `KJIP_ASSERT_NOW(a_last_mark, rsp_valid && !rsp_payload.motion_done, rsp_payload.last_joint == (32'(rsp_payload.joint_out) == JOINTS - 1), "last_joint misplaced")

endmodule

bind keyframe_joint_interpolator_unit kjip_checker #(.JOINTS(JOINTS)) u_kjip_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe joint interpolator testbench
// A directed table followed by random loads and ticks across several frame
// counts. Each response is checked against an in-bench interpolation model.
// ----------------------------------------------------------------------------
module tb_top;
   import kjip_pkg::*;

   localparam int JN         = KJIP_JOINTS;
   localparam int FN         = KJIP_MAX_FRAMES;
   localparam int ITEM_GOAL  = 470;
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD  = 3000;
   localparam int MAX_SHOWN  = 10;

   localparam kjip_rsp_type DONE_RSP = '{joint_out: 5'd0, angle_out: 16'sd0,
                                         last_joint: 1'b1, motion_done: 1'b1};

   typedef struct {
      kjip_req_type req;
      bit           typed;
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   kjip_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   kjip_rsp_type rsp_payload;
   logic         csr_write_enable = 1'b0;
   logic [6:0]   csr_write_data = '0;

   // Shadow copy of the block state.
   logic [15:0]        key_time [FN];
   logic signed [15:0] key_angle [FN][JN];
   logic signed [15:0] start_angle [JN];
   bit                 time_written [FN];
   bit                 angle_written [FN][JN];
   int unsigned        frame_count_shadow;

   kjip_rsp_type angle_q[$];
   int  mismatch_count;
   int  items_sent;
   int  responses_seen;
   int  idle_cycles;
   int  burst_left;
   bit  hold_done;

   keyframe_joint_interpolator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned loaded_frames();
      return (frame_count_shadow > FN) ? FN : frame_count_shadow;
   endfunction

   // Finds the frame in force and the following frame for an elapsed time.
   function automatic void find_segment(input logic [15:0] t, output bit has_prev,
                                        output int prev, output int nxt);
      int unsigned n;
      n = loaded_frames();
      has_prev = 0;
      prev = 0;
      nxt = n - 1;
      for (int i = n - 1; i >= 0; i--) begin
         if (t >= key_time[i]) begin
            has_prev = 1;
            prev = i;
            break;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (t < key_time[i]) begin
            nxt = i;
            break;
         end
      end
   endfunction

   function automatic bit frame_full(input int f);
      for (int j = 0; j < JN; j++) begin
         if (!angle_written[f][j]) return 0;
      end
      return 1;
   endfunction

   // A tick is legal only if every table entry it reads has been loaded.
   function automatic bit tick_is_legal(input logic [15:0] t);
      int unsigned n;
      bit has_prev;
      int prev;
      int nxt;
      n = loaded_frames();
      if (n == 0) return 1;
      for (int i = 0; i < n; i++) begin
         if (!time_written[i]) return 0;
      end
      if (t >= key_time[n - 1]) return 1;
      find_segment(t, has_prev, prev, nxt);
      if (has_prev && !frame_full(prev)) return 0;
      return frame_full(nxt);
   endfunction

   // Applies one accepted transfer to the shadow state and queues its responses.
   function automatic void interpolate_req(input kjip_req_type r, input bit typed);
      int unsigned n;
      bit has_prev;
      int prev;
      int nxt;
      longint tp;
      longint tn;
      longint tv;
      longint a;
      longint b;
      longint q;
      kjip_rsp_type rsp;
      case (kjip_op_type'(r.operation))
         OP_FRAME_TIME: begin
            key_time[r.frame_index] = r.time_ms;
            time_written[r.frame_index] = 1;
         end
         OP_FRAME_ANGLE: begin
            if (r.joint_index < JN) begin
               key_angle[r.frame_index][r.joint_index] = r.position;
               angle_written[r.frame_index][r.joint_index] = 1;
            end
         end
         OP_START_ANGLE: begin
            if (r.joint_index < JN) start_angle[r.joint_index] = r.position;
         end
         default: begin
            n = loaded_frames();
            if (typed || n == 0 || r.time_ms >= key_time[n - 1]) begin
               angle_q = {angle_q, DONE_RSP};
            end else begin
               find_segment(r.time_ms, has_prev, prev, nxt);
               tp = has_prev ? longint'(key_time[prev]) : 0;
               tn = longint'(key_time[nxt]);
               tv = longint'(r.time_ms);
               for (int j = 0; j < JN; j++) begin
                  a = has_prev ? longint'(key_angle[prev][j]) : longint'(start_angle[j]);
                  b = longint'(key_angle[nxt][j]);
                  q = (a * (tn - tv) + b * (tv - tp)) / (tn - tp);
                  rsp.joint_out = j[4:0];
                  rsp.angle_out = q[15:0];
                  rsp.last_joint = (j == JN - 1);
                  rsp.motion_done = 1'b0;
                  angle_q = {angle_q, rsp};
               end
            end
         end
      endcase
   endfunction

   // Offers one item in bursts with random gaps, and predicts it on acceptance.
   task automatic send_req(input kjip_req_type r, input bit typed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      interpolate_req(r, typed);
      items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // Waits for all responses, lets trailing loads retire, then writes the count.
   task automatic write_frame_count(input int unsigned value);
      req_valid = 1'b0;
      while (angle_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value[6:0];
      @(negedge clock);
      csr_write_enable = 1'b0;
      frame_count_shadow = value;
   endtask

   function automatic kjip_req_type make_req(input kjip_op_type op, input int fi,
                                             input int ji, input int t, input int pos);
      kjip_req_type r;
      r.operation = op;
      r.frame_index = fi[5:0];
      r.joint_index = ji[4:0];
      r.time_ms = t[15:0];
      r.position = pos[15:0];
      return r;
   endfunction

   // Response checker: each transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      kjip_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (angle_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("unexpected response: %p", rsp_payload);
         end else begin
            want = angle_q.pop_front();
            if (rsp_payload.joint_out !== want.joint_out
                || rsp_payload.angle_out !== want.angle_out
                || rsp_payload.last_joint !== want.last_joint
                || rsp_payload.motion_done !== want.motion_done) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("response mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer happens on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("keyframe_joint_interpolator_unit test failed");
            $finish;
         end
      end
   end

   // Receiver stall pattern, with one long hold once the traffic is going.
   initial begin
      int mode;
      int run;
      forever begin
         mode = $urandom_range(0, 3);
         run = $urandom_range(10, 80);
         if (!hold_done && responses_seen > 100) begin
            hold_done = 1;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            repeat (run) begin
               @(negedge clock);
               case (mode)
                  0: rsp_stall = 1'b0;
                  1: rsp_stall = ($urandom_range(0, 1) == 0);
                  2: rsp_stall = ($urandom_range(0, 3) == 0);
                  default: rsp_stall = ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   // Main sequence.
   initial begin
      table_row_type directed[$];
      int phase_counts[] = '{1, 2, 4, 64, 127, 3, 0, 64, 2};
      int phase;
      int kind;
      int fi;
      int ji;
      int t;
      int tmax;
      int f_end;
      bit found;
      kjip_req_type r;

      for (int j = 0; j < JN; j++) start_angle[j] = '0;
      frame_count_shadow = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      write_frame_count(0);

      // Directed table: with no frames loaded every tick reports done.
      directed.insert(directed.size(), '{make_req(OP_TICK, 0, 0, 0, 0), 1});
      directed.insert(directed.size(), '{make_req(OP_TICK, 63, 31, 16'hFFFF, 16'hFFFF), 1});
      directed.insert(directed.size(), '{make_req(OP_START_ANGLE, 0, 0, 0, 16'h7FFF), 0});
      directed.insert(directed.size(), '{make_req(OP_START_ANGLE, 63, 24, 0, 16'h8000), 0});
      directed.insert(directed.size(), '{make_req(OP_START_ANGLE, 0, 31, 0, 16'h1234), 0});
      directed.insert(directed.size(), '{make_req(OP_START_ANGLE, 0, 25, 0, 16'hFFFF), 0});
      directed.insert(directed.size(), '{make_req(OP_FRAME_TIME, 63, 0, 16'hFFFF, 0), 0});
      directed.insert(directed.size(), '{make_req(OP_FRAME_TIME, 0, 0, 0, 0), 0});
      directed.insert(directed.size(), '{make_req(OP_FRAME_ANGLE, 63, 31, 0, 16'h5555), 0});
      directed.insert(directed.size(), '{make_req(OP_FRAME_ANGLE, 0, 25, 0, 16'hAAAA), 0});
      directed.insert(directed.size(), '{make_req(OP_TICK, 0, 0, 16'h8000, 0), 1});
      directed.insert(directed.size(), '{make_req(OP_TICK, 0, 0, 16'h7FFF, 0), 1});
      foreach (directed[k]) send_req(directed[k].req, directed[k].typed);

      // Load angles for the first four frames, with the extremes on two joints.
      for (int f = 0; f < 4; f++) begin
         for (int j = 0; j < JN; j++) begin
            if (j == 0) t = 16'h8000;
            else if (j == JN - 1) t = 16'h7FFF;
            else t = $urandom_range(0, 16'hFFFF);
            send_req(make_req(OP_FRAME_ANGLE, f, j, 0, t), 0);
         end
      end
      // Ascending times for frames 0 to 3, the rest equal to frame 3.
      tmax = $urandom_range(1, 4000);
      for (int f = 0; f < FN; f++) begin
         if (f < 4) tmax = tmax + $urandom_range(1, 15000);
         send_req(make_req(OP_FRAME_TIME, f, 0, tmax, 0), 0);
      end

      // Random part, one frame count per phase.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         if (phase < phase_counts.size() && (items_sent % 40) == 0) begin
            write_frame_count(phase_counts[phase]);
            phase++;
         end
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            found = 0;
            f_end = loaded_frames();
            tmax = (f_end == 0) ? 16'hFFFF : int'(key_time[f_end - 1]);
            for (int k = 0; k < 8 && !found; k++) begin
               t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16'hFFFF)
                                               : $urandom_range(0, tmax);
               found = tick_is_legal(t[15:0]);
            end
            if (found) send_req(make_req(OP_TICK, $urandom_range(0, 63),
                                         $urandom_range(0, 31), t,
                                         $urandom_range(0, 16'hFFFF)), 0);
         end else if (kind < 75) begin
            fi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
            ji = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
            send_req(make_req(OP_FRAME_ANGLE, fi, ji, $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF)), 0);
         end else if (kind < 88) begin
            ji = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
            send_req(make_req(OP_START_ANGLE, $urandom_range(0, 63), ji,
                              $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF)), 0);
         end else begin
            // Time rewrites on the early frames also produce unordered tables.
            fi = $urandom_range(0, 3);
            send_req(make_req(OP_FRAME_TIME, fi, $urandom_range(0, 31),
                              $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF)), 0);
         end
      end

      // Drain and report.
      req_valid = 1'b0;
      while (angle_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("keyframe_joint_interpolator_unit test passed");
      end else begin
         $display("keyframe_joint_interpolator_unit test failed");
      end
      $finish;
   end

endmodule
